// ===== hdl/dbnc_pkg.sv =====
package dbnc_pkg;

  // Field and register widths
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned BTN_W   = 5;
  localparam int unsigned PH_W    = 2;
  localparam int unsigned ENTRY_W = PH_W + TIME_W;
  localparam int unsigned IDX_W   = 3;

  // Channel count limits
  localparam int unsigned MAX_CHANNELS    = 32;
  localparam int unsigned NUM_BUTTONS_DEF = 32;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_PRESS_TIME   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_RELEASE_TIME = 3'd1;
  localparam logic [IDX_W-1:0] CFG_DEAD_TIME    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_DEFAULT_TIME = 3'd3;
  localparam logic [IDX_W-1:0] CFG_MIN_TIME     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [TIME_W-1:0] DEFAULT_TIME_RST = 16'd30;
  localparam logic [TIME_W-1:0] MIN_TIME_RST     = 16'd10;

  // Channel phase as stored in the state memory
  typedef enum logic [PH_W-1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2,
    PH_DEAD    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] release_time;
    logic [TIME_W-1:0] dead_time;
    logic [TIME_W-1:0] default_time;
    logic [TIME_W-1:0] min_time;
  } cfg_t;

endpackage

// ===== hdl/dbnc_ram.sv =====
module dbnc_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dbnc_ctrl.sv =====
module dbnc_ctrl #(
  parameter int unsigned CHANNELS = dbnc_pkg::MAX_CHANNELS,
  localparam int unsigned AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dbnc_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [dbnc_pkg::BTN_W-1:0]     button_i,
  input  logic                           is_release_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dbnc_pkg::BTN_W-1:0]     event_button_o,
  output logic                           event_release_o,
  output logic                           last_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [dbnc_pkg::ENTRY_W-1:0]   mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [dbnc_pkg::ENTRY_W-1:0]   mem_rdata_i
);

  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(CHANNELS - 1);
  localparam logic [dbnc_pkg::BTN_W:0] CH_LIMIT = (dbnc_pkg::BTN_W + 1)'(CHANNELS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       mode_q, mode_d;
  logic       rel_q, rel_d;
  logic       rd_pend_q, rd_pend_d;
  logic [CNT_W-1:0] rd_ch_q, rd_ch_d;
  logic       ev_valid_q, ev_valid_d;
  logic [AW-1:0] ev_ch_q, ev_ch_d;
  logic [CHANNELS-1:0] written_q;

  logic pend_valid_q, pend_valid_d;
  logic [dbnc_pkg::BTN_W-1:0] pend_btn_q, pend_btn_d;
  logic pend_rel_q, pend_rel_d;

  logic out_valid_q, out_valid_d;
  logic [dbnc_pkg::BTN_W-1:0] out_btn_q;
  logic out_rel_q, out_last_q;

  // Entry under evaluation; an entry never written reads as idle
  dbnc_pkg::phase_e       ph;
  logic [dbnc_pkg::TIME_W-1:0] cnt;
  logic [dbnc_pkg::TIME_W-1:0] sel_t, eff_t;

  logic wr_need, res_gen, res_rel;
  dbnc_pkg::phase_e wr_ph;
  logic [dbnc_pkg::TIME_W-1:0] wr_cnt;

  logic out_free, stall, fire, issue, push_mid, push_last, push, in_acc;

  assign ph  = written_q[ev_ch_q]
             ? dbnc_pkg::phase_e'(mem_rdata_i[dbnc_pkg::ENTRY_W-1 -: dbnc_pkg::PH_W])
             : dbnc_pkg::PH_IDLE;
  assign cnt = written_q[ev_ch_q] ? mem_rdata_i[dbnc_pkg::TIME_W-1:0] : '0;

  assign sel_t = rel_q ? cfg_i.release_time : cfg_i.press_time;
  assign eff_t = (sel_t == '0) ? cfg_i.default_time : sel_t;

  // Next entry value and result for the channel under evaluation
  always_comb begin
    wr_need = 1'b0;
    wr_ph   = ph;
    wr_cnt  = cnt;
    res_gen = 1'b0;
    res_rel = rel_q;
    if (!mode_q) begin
      unique case (ph)
        dbnc_pkg::PH_IDLE: begin
          if (eff_t > cfg_i.min_time) begin
            wr_need = 1'b1;
            wr_ph   = rel_q ? dbnc_pkg::PH_RELEASE : dbnc_pkg::PH_PRESS;
            wr_cnt  = eff_t;
          end else begin
            res_gen = 1'b1;
          end
        end
        dbnc_pkg::PH_PRESS: begin
          if (rel_q) begin
            wr_need = 1'b1;
            wr_ph   = dbnc_pkg::PH_IDLE;
            wr_cnt  = '0;
            res_gen = 1'b1;
            res_rel = 1'b1;
          end
        end
        dbnc_pkg::PH_RELEASE: begin
          if (!rel_q && cfg_i.release_time != '0) begin
            wr_need = 1'b1;
            wr_ph   = dbnc_pkg::PH_IDLE;
            wr_cnt  = '0;
          end
        end
        dbnc_pkg::PH_DEAD: begin
        end
      endcase
    end else if (ph != dbnc_pkg::PH_IDLE) begin
      wr_need = 1'b1;
      if (cnt > dbnc_pkg::TIME_W'(1)) begin
        wr_cnt = cnt - 1'b1;
      end else if (ph == dbnc_pkg::PH_DEAD) begin
        wr_ph  = dbnc_pkg::PH_IDLE;
        wr_cnt = '0;
      end else begin
        res_gen = 1'b1;
        res_rel = (ph == dbnc_pkg::PH_RELEASE);
        if (cfg_i.dead_time != '0) begin
          wr_ph  = dbnc_pkg::PH_DEAD;
          wr_cnt = cfg_i.dead_time;
        end else begin
          wr_ph  = dbnc_pkg::PH_IDLE;
          wr_cnt = '0;
        end
      end
    end
  end

  // A new result displaces the held one into the output register
  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = ev_valid_q && res_gen && pend_valid_q && !out_free;
  assign fire      = ev_valid_q && !stall;
  assign issue     = (state_q == S_SCAN) && rd_pend_q && !stall;
  assign push_mid  = fire && res_gen && pend_valid_q;
  assign push_last = (state_q == S_FLUSH) && pend_valid_q && out_free;
  assign push      = push_mid || push_last;
  assign in_acc    = in_valid_i && in_ready_o;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    rel_d        = rel_q;
    rd_pend_d    = rd_pend_q;
    rd_ch_d      = rd_ch_q;
    ev_valid_d   = ev_valid_q;
    ev_ch_d      = ev_ch_q;
    pend_valid_d = pend_valid_q;
    pend_btn_d   = pend_btn_q;
    pend_rel_d   = pend_rel_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (push) begin
      out_valid_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d   = S_SCAN;
          mode_d    = mode_i;
          rel_d     = is_release_i;
          rd_pend_d = mode_i || ({1'b0, button_i} < CH_LIMIT);
          rd_ch_d   = mode_i ? '0 : CNT_W'(button_i);
        end
      end
      S_SCAN: begin
        if (!stall) begin
          ev_valid_d = issue;
          if (issue) begin
            ev_ch_d = rd_ch_q[AW-1:0];
            if (!mode_q || rd_ch_q == LAST_CH) begin
              rd_pend_d = 1'b0;
            end else begin
              rd_ch_d = rd_ch_q + 1'b1;
            end
          end
        end
        if (fire && res_gen) begin
          pend_valid_d = 1'b1;
          pend_btn_d   = dbnc_pkg::BTN_W'(ev_ch_q);
          pend_rel_d   = res_rel;
        end
        if (!rd_pend_q && !stall) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_pend_q    <= 1'b0;
      ev_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      written_q    <= '0;
    end else begin
      state_q      <= state_d;
      rd_pend_q    <= rd_pend_d;
      ev_valid_q   <= ev_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (mem_we_o) begin
        written_q[ev_ch_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    rel_q      <= rel_d;
    rd_ch_q    <= rd_ch_d;
    ev_ch_q    <= ev_ch_d;
    pend_btn_q <= pend_btn_d;
    pend_rel_q <= pend_rel_d;
    if (push) begin
      out_btn_q  <= pend_btn_q;
      out_rel_q  <= pend_rel_q;
      out_last_q <= push_last;
    end
  end

  assign mem_we_o    = fire && wr_need;
  assign mem_waddr_o = ev_ch_q;
  assign mem_wdata_o = {wr_ph, wr_cnt};
  assign mem_re_o    = issue;
  assign mem_raddr_o = rd_ch_q[AW-1:0];

  assign out_valid_o     = out_valid_q;
  assign event_button_o  = out_btn_q;
  assign event_release_o = out_rel_q;
  assign last_o          = out_last_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o && mem_re_o |-> mem_waddr_o != mem_raddr_o)
    else $error("state memory read and write hit the same channel");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q && !ev_valid_q && !rd_pend_q)
    else $error("request taken while work is still in flight");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_q && stall |=> ev_valid_q && $stable(ev_ch_q))
    else $error("stalled channel lost before write-back");

  a_flush_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |-> !rd_pend_q && !ev_valid_q)
    else $error("flush entered with channels left to visit");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten while full");

endmodule

// ===== hdl/multichannel_button_debouncer_top.sv =====
// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  mode_i, button_i, is_release_i
// out       out_valid_o/out_ready_i event_button_o, event_release_o, last_o
// cfg       cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// A tick request makes one state-memory read per channel through the
// single read port, with evaluation of each channel overlapped with the
// read of the next. Reset clears all channels to idle at once through
// per-channel written bits. A result that finds both the held result and
// the output register full stalls the channel scan until the output
// register is taken.
module multichannel_button_debouncer_top #(
  parameter int unsigned NUM_BUTTONS = dbnc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [dbnc_pkg::BTN_W-1:0]      button_i,
  input  logic                            is_release_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dbnc_pkg::BTN_W-1:0]      event_button_o,
  output logic                            event_release_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic [dbnc_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [dbnc_pkg::TIME_W-1:0]     cfg_data_i
);

  // Clamp the channel count to what the 5-bit button field can address
  localparam int unsigned CHANNELS = (NUM_BUTTONS > dbnc_pkg::MAX_CHANNELS)
                                   ? dbnc_pkg::MAX_CHANNELS : NUM_BUTTONS;
  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dbnc_pkg::cfg_t cfg_q;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [dbnc_pkg::ENTRY_W-1:0]  mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [dbnc_pkg::ENTRY_W-1:0]  mem_rdata;

  // Configuration registers; writes to unused indexes drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_time   <= '0;
      cfg_q.release_time <= '0;
      cfg_q.dead_time    <= '0;
      cfg_q.default_time <= dbnc_pkg::DEFAULT_TIME_RST;
      cfg_q.min_time     <= dbnc_pkg::MIN_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dbnc_pkg::CFG_PRESS_TIME:   cfg_q.press_time   <= cfg_data_i;
        dbnc_pkg::CFG_RELEASE_TIME: cfg_q.release_time <= cfg_data_i;
        dbnc_pkg::CFG_DEAD_TIME:    cfg_q.dead_time    <= cfg_data_i;
        dbnc_pkg::CFG_DEFAULT_TIME: cfg_q.default_time <= cfg_data_i;
        dbnc_pkg::CFG_MIN_TIME:     cfg_q.min_time     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Per-channel phase and countdown, one entry per channel
  dbnc_ram #(
    .WIDTH (dbnc_pkg::ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer: read, update and write back each visited channel
  dbnc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .button_i        (button_i),
    .is_release_i    (is_release_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_button_o  (event_button_o),
    .event_release_o (event_release_o),
    .last_o          (last_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

endmodule
